@@ rtl/wrbp_pkg.sv @@
package wrbp_pkg;

  // Bin counts
  localparam int NUM_BINS    = 4;
  localparam int REG_BINS    = 4;
  localparam int ACTIVE_BINS = (NUM_BINS < REG_BINS) ? NUM_BINS : REG_BINS;

  // Field widths
  localparam int WEIGHT_W = 16;
  localparam int VALUE_W  = 32;
  localparam int WORD_W   = 31;
  localparam int BIN_W    = 2;
  localparam int SUM_W    = WEIGHT_W + $clog2(ACTIVE_BINS);

  // Register port
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = $clog2(REG_BINS);
  localparam int ADDR_W    = REG_IDX_W + 3;

  localparam logic REG_GRP_WEIGHT = 1'b0;
  localparam logic REG_GRP_VALUE  = 1'b1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RST [REG_BINS] = '{16'd1, 16'd1, 16'd0, 16'd0};
  localparam logic [VALUE_W-1:0]  VALUE_RST  [REG_BINS] = '{32'd1, 32'd0, 32'd0, 32'd0};

  // Modulo pipeline: restoring remainder, a few dividend bits per stage
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = (WORD_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int PAD_W          = DIV_STAGES * BITS_PER_STAGE;

  typedef struct packed {
    logic [ACTIVE_BINS-1:0][SUM_W-1:0]   prefix;
    logic [ACTIVE_BINS-1:0][VALUE_W-1:0] value;
    logic                                sum_zero;
  } cfg_t;

  // One restoring step: shift in a dividend bit, subtract the divisor if it fits.
  function automatic logic [SUM_W-1:0] mod_step(input logic [SUM_W-1:0] rem,
                                                input logic              din,
                                                input logic [SUM_W-1:0] sum);
    logic [SUM_W:0] t;
    t = {rem, din};
    if (t >= {1'b0, sum}) begin
      t = t - {1'b0, sum};
    end
    return t[SUM_W-1:0];
  endfunction

endpackage

@@ rtl/weighted_random_bin_picker.sv @@
// Pipeline: an accepted request passes an input register, 16 modulo stages at 2
// dividend bits each, and a select register before its result reaches the output.
// Throughput: one request per cycle; stalls only back up through full stages.
// Reset: weights return to 1,1,0,0 and values to 1,0,0,0; the pipeline empties.
// Weight sums are re-registered every cycle and follow a register write in the cycle after it.
module weighted_random_bin_picker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [wrbp_pkg::WORD_W-1:0]          random_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [wrbp_pkg::VALUE_W-1:0]  chosen_value_o,
  output logic [wrbp_pkg::BIN_W-1:0]           chosen_bin_o,
  output logic                                 no_weight_error_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [wrbp_pkg::ADDR_W-1:0]          paddr,
  input  logic [wrbp_pkg::DATA_W-1:0]          pwdata,
  output logic [wrbp_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);
  import wrbp_pkg::*;

  cfg_t             cfg;
  logic             pipe_valid;
  logic             sel_stall;
  logic [SUM_W-1:0] pipe_rem;

  wrbp_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  wrbp_mod_pipe u_mod_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .word_i     (random_word_i),
    .sum_i      (cfg.prefix[ACTIVE_BINS-1]),
    .out_valid_o(pipe_valid),
    .out_stall_i(sel_stall),
    .rem_o      (pipe_rem)
  );

  wrbp_select u_select (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (pipe_valid),
    .stall_o          (sel_stall),
    .rem_i            (pipe_rem),
    .cfg_i            (cfg),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .chosen_value_o   (chosen_value_o),
    .chosen_bin_o     (chosen_bin_o),
    .no_weight_error_o(no_weight_error_o)
  );

endmodule

@@ rtl/wrbp_regs.sv @@
module wrbp_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wrbp_pkg::ADDR_W-1:0] paddr,
  input  logic [wrbp_pkg::DATA_W-1:0] pwdata,
  output logic [wrbp_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output wrbp_pkg::cfg_t              cfg_o
);
  import wrbp_pkg::*;

  logic [WEIGHT_W-1:0]  weight_q [REG_BINS];
  logic [VALUE_W-1:0]   value_q  [REG_BINS];
  logic                 wr_en;
  logic                 grp;
  logic [REG_IDX_W-1:0] idx;
  cfg_t                 cfg_d, cfg_q;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign grp    = paddr[ADDR_W-1];
  assign idx    = paddr[ADDR_W-2:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_BINS; i++) begin
        weight_q[i] <= WEIGHT_RST[i];
        value_q[i]  <= VALUE_RST[i];
      end
    end else if (wr_en) begin
      unique case (grp)
        REG_GRP_WEIGHT: weight_q[idx] <= pwdata[WEIGHT_W-1:0];
        REG_GRP_VALUE:  value_q[idx]  <= pwdata[VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (grp)
      REG_GRP_WEIGHT: prdata = {{(DATA_W-WEIGHT_W){1'b0}}, weight_q[idx]};
      REG_GRP_VALUE:  prdata = value_q[idx];
      default: ;
    endcase
  end

  // Running weight sums, held in registers so the datapath sees a flat compare
  always_comb begin
    logic [SUM_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < ACTIVE_BINS; i++) begin
      acc             = acc + SUM_W'(weight_q[i]);
      cfg_d.prefix[i] = acc;
      cfg_d.value[i]  = value_q[i];
    end
    cfg_d.sum_zero = (acc == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/wrbp_mod_pipe.sv @@
module wrbp_mod_pipe (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [wrbp_pkg::WORD_W-1:0] word_i,
  input  logic [wrbp_pkg::SUM_W-1:0]  sum_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [wrbp_pkg::SUM_W-1:0]  rem_o
);
  import wrbp_pkg::*;

  logic             v_q       [DIV_STAGES+1];
  logic             en        [DIV_STAGES+1];
  logic [PAD_W-1:0] word_q    [DIV_STAGES+1];
  logic [SUM_W-1:0] rem_q     [DIV_STAGES+1];
  logic [SUM_W-1:0] step_rem  [DIV_STAGES+1];

  // A stage may load when it is empty or its content moves on
  always_comb begin
    en[DIV_STAGES] = !v_q[DIV_STAGES] || !out_stall_i;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    logic [SUM_W-1:0] r;
    step_rem[0] = '0;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      r = rem_q[k-1];
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        r = mod_step(r, word_q[k-1][PAD_W-1-(k-1)*BITS_PER_STAGE-b], sum_i);
      end
      step_rem[k] = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      word_q[0] <= PAD_W'(word_i);
      rem_q[0]  <= '0;
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (en[k] && v_q[k-1]) begin
        word_q[k] <= word_q[k-1];
        rem_q[k]  <= step_rem[k];
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[DIV_STAGES];
  assign rem_o       = rem_q[DIV_STAGES];

`ifndef SYNTHESIS
  a_rem_below_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[DIV_STAGES] && (sum_i != '0)) |-> (rem_q[DIV_STAGES] < sum_i))
    else $error("remainder not reduced below weight sum");

  a_tail_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[DIV_STAGES] && out_stall_i) |=> (v_q[DIV_STAGES] && $stable(rem_q[DIV_STAGES])))
    else $error("stalled pipeline tail lost or changed its request");
`endif

endmodule

@@ rtl/wrbp_select.sv @@
module wrbp_select (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic [wrbp_pkg::SUM_W-1:0]         rem_i,
  input  wrbp_pkg::cfg_t                     cfg_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [wrbp_pkg::VALUE_W-1:0] chosen_value_o,
  output logic [wrbp_pkg::BIN_W-1:0]         chosen_bin_o,
  output logic                               no_weight_error_o
);
  import wrbp_pkg::*;

  logic               en;
  logic [SUM_W:0]     target;
  logic [BIN_W-1:0]   bin_d, bin_q;
  logic [VALUE_W-1:0] value_d, value_q;
  logic               err_d, err_q;
  logic               out_valid_q;

  assign target = {1'b0, rem_i} + (SUM_W+1)'(1);

  // First bin whose running sum reaches the target; a zero weight sum flags an error with bin and value zero
  always_comb begin
    logic found;
    found   = 1'b0;
    bin_d   = '0;
    value_d = '0;
    for (int i = 0; i < ACTIVE_BINS; i++) begin
      if (!found && ({1'b0, cfg_i.prefix[i]} >= target)) begin
        found   = 1'b1;
        bin_d   = BIN_W'(i);
        value_d = cfg_i.value[i];
      end
    end
    err_d = cfg_i.sum_zero;
    if (cfg_i.sum_zero) begin
      bin_d   = '0;
      value_d = '0;
    end
  end

  assign en      = !out_valid_q || !out_stall_i;
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      bin_q   <= bin_d;
      value_q <= value_d;
      err_q   <= err_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign chosen_value_o    = $signed(value_q);
  assign chosen_bin_o      = bin_q;
  assign no_weight_error_o = err_q;

`ifndef SYNTHESIS
  a_err_clears_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && err_q) |-> ((value_q == '0) && (bin_q == '0)))
    else $error("error result carries a value or bin");

  a_err_only_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && en && !cfg_i.sum_zero) |=> (out_valid_q && !err_q))
    else $error("error flagged with nonzero weight sum");
`endif

endmodule
